// ===== hw/rtl/tfd_pkg.sv =====
package tfd_pkg;

  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam int unsigned DESC_BYTES  = 9;
  localparam int unsigned DIDX_W      = $clog2(DESC_BYTES);

  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] FLAG_BYTE     = 8'h7e;
  localparam logic [7:0] ESC_BYTE      = 8'h7d;
  localparam logic [7:0] ESC_MASK      = 8'h20;
  localparam logic [7:0] TYPE_LINK     = 8'hfe;
  localparam logic [7:0] TYPE_USER     = 8'hfd;
  localparam logic [7:0] TYPE_ALARM_HI = 8'hfc;
  localparam logic [7:0] TYPE_ALARM_LO = 8'hf9;
  localparam logic [2:0] USER_CNT_MASK = 3'h7;
  localparam logic [1:0] URG_MASK      = 2'h3;

  localparam logic [2:0] LINK_RESULTS  = 3'd4;
  localparam logic [2:0] ONE_RESULT    = 3'd1;
  localparam logic [1:0] LAST_CHAN     = 2'd3;
  localparam logic [3:0] USER_OFFSET   = 4'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_FRAME = 4'b0100,
    PH_ESC   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LINK  = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_USER  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                           kind;
    logic [1:0]                      slot;
    logic [DESC_BYTES-1:0][7:0]      data;
  } desc_t;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] slot;
    logic [7:0] value;
    logic [7:0] min_value;
    logic [7:0] max_value;
    logic       above;
    logic [1:0] urgency;
    logic       last;
  } result_t;

endpackage

// ===== hw/rtl/tfd_front.sv =====
module tfd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            line_error_i,
  output logic            push_o,
  output tfd_pkg::desc_t  desc_o
);
  import tfd_pkg::*;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [7:0]         store_q [FRAME_BYTES];
  logic               store_en;
  logic [7:0]         store_byte;
  logic [7:0]         ftype;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    store_en   = 1'b0;
    store_byte = rx_byte_i;
    push_o     = 1'b0;
    if (take_i && !line_error_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == FLAG_BYTE) begin
            count_d = '0;
            phase_d = PH_START;
          end
        end
        PH_START: begin
          if (rx_byte_i == ESC_BYTE) begin
            phase_d = PH_ESC;
          end else if (rx_byte_i != FLAG_BYTE) begin
            store_en = 1'b1;
            phase_d  = PH_FRAME;
          end
        end
        PH_ESC: begin
          store_en   = 1'b1;
          store_byte = rx_byte_i ^ ESC_MASK;
          phase_d    = PH_FRAME;
        end
        PH_FRAME: begin
          if (rx_byte_i == ESC_BYTE) begin
            phase_d = PH_ESC;
          end else if (rx_byte_i == FLAG_BYTE) begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
          end else begin
            store_en = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    if (store_en && (count_q < CNT_W'(FRAME_BYTES))) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        store_q[k] <= '0;
      end
    end else if (store_en && (count_q < CNT_W'(FRAME_BYTES))) begin
      store_q[count_q[IDX_W-1:0]] <= store_byte;
    end
  end

  assign ftype = store_q[0];

  always_comb begin
    desc_o.slot = 2'd0;
    if (ftype == TYPE_LINK) begin
      desc_o.kind = KIND_LINK;
    end else if ((ftype >= TYPE_ALARM_LO) && (ftype <= TYPE_ALARM_HI)) begin
      desc_o.kind = KIND_ALARM;
      desc_o.slot = ftype[1:0] - TYPE_ALARM_LO[1:0];
    end else if (ftype == TYPE_USER) begin
      desc_o.kind = KIND_USER;
    end else begin
      desc_o.kind = KIND_OTHER;
    end
    for (int k = 0; k < DESC_BYTES; k++) begin
      desc_o.data[k] = store_q[IDX_W'(k + 1)];
    end
  end

endmodule

// ===== hw/rtl/tfd_queue.sv =====
module tfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tfd_pkg::desc_t  din_i,
  output logic            full_o,
  output logic            valid_o,
  output tfd_pkg::desc_t  dout_o,
  input  logic            pop_i
);
  import tfd_pkg::*;

  desc_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

// ===== hw/rtl/tfd_back.sv =====
module tfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tfd_pkg::desc_t    q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfd_pkg::result_t  res_o
);
  import tfd_pkg::*;

  logic [2:0]  step_q;
  logic [2:0]  total;
  logic [1:0]  chan;
  logic [7:0]  link_v;
  logic [7:0]  min_q [4];
  logic [7:0]  max_q [4];
  logic [7:0]  new_min, new_max;
  logic        out_free, emit, fin;
  logic        out_valid_q;
  result_t     res_q, res_d;

  assign chan   = step_q[1:0];
  assign link_v = (chan == LAST_CHAN) ? {1'b0, q_data_i.data[chan][7:1]}
                                      : q_data_i.data[chan];
  assign new_min = ((min_q[chan] == '0) || (min_q[chan] > link_v)) ? link_v : min_q[chan];
  assign new_max = ((max_q[chan] == '0) || (max_q[chan] < link_v)) ? link_v : max_q[chan];

  always_comb begin
    res_d      = '0;
    res_d.kind = q_data_i.kind;
    unique case (q_data_i.kind)
      KIND_LINK: begin
        total           = LINK_RESULTS;
        res_d.slot      = chan;
        res_d.value     = link_v;
        res_d.min_value = new_min;
        res_d.max_value = new_max;
      end
      KIND_ALARM: begin
        total         = ONE_RESULT;
        res_d.slot    = q_data_i.slot;
        res_d.value   = q_data_i.data[0];
        res_d.above   = q_data_i.data[1][0];
        res_d.urgency = q_data_i.data[2][1:0] & URG_MASK;
      end
      KIND_USER: begin
        total       = q_data_i.data[0][2:0] & USER_CNT_MASK;
        res_d.value = q_data_i.data[DIDX_W'(step_q) + DIDX_W'(USER_OFFSET)];
      end
      default: begin
        total = ONE_RESULT;
      end
    endcase
    res_d.last = (step_q == total - 3'd1);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = q_valid_i && out_free && (total != '0);
  assign fin      = (total == '0) || (step_q == total - 3'd1);
  assign q_pop_o  = q_valid_i && out_free && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
    end else begin
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (q_pop_o) begin
        step_q <= '0;
      end else if (emit) begin
        step_q <= step_q + 3'd1;
      end
      if (emit && (q_data_i.kind == KIND_LINK)) begin
        min_q[chan] <= new_min;
        max_q[chan] <= new_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty frame queue");
  a_step_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid_i |-> (step_q == '0))
    else $error("step counter not cleared between frames");
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_d.last) |-> q_pop_o)
    else $error("final result emitted without releasing frame");
  a_link_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.kind == KIND_LINK)) |->
      ((res_q.min_value <= res_q.value) && (res_q.value <= res_q.max_value)))
    else $error("link channel value outside min/max");
`endif

endmodule

// ===== hw/rtl/telemetry_frame_deframer_core.sv =====
// Telemetry frame deframer.
// Input channel: in_valid_i / in_stall_o with rx_byte_i and line_error_i.
// Bytes with line_error_i set are consumed and ignored. Frames open and
// close with 0x7E; 0x7D escapes the next byte (XOR 0x20).
// Output channel: out_valid_o / out_stall_i with one result per transaction
// (kind, slot, value, min/max, alarm direction and urgency, last).
// The front takes one byte per cycle unless stalled. A closing flag pushes a
// frame snapshot into a two-entry queue; in_stall_o is high while that queue
// is full. The back emits one result per cycle from the queue head while the
// receiver does not stall: four for a link frame, one for alarm or other
// frames, 0..7 for a user frame. The first result of a frame is offered once
// its snapshot has been queued and its result registered at the output.
// When the receiver stalls, the output register holds its result,
// the back waits, the queue fills, and then input bytes are stalled.
// Reset clears the parse state, the frame store and the channel min/max
// values; no result is pending after reset.
module telemetry_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       line_error_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [1:0] slot_o,
  output logic [7:0] value_o,
  output logic [7:0] min_value_o,
  output logic [7:0] max_value_o,
  output logic       above_o,
  output logic [1:0] urgency_o,
  output logic       last_o
);
  import tfd_pkg::*;

  logic     take, push, full, q_valid, q_pop;
  desc_t    push_desc, head_desc;
  result_t  res;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  tfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .rx_byte_i    (rx_byte_i),
    .line_error_i (line_error_i),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  tfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_desc),
    .full_o  (full),
    .valid_o (q_valid),
    .dout_o  (head_desc),
    .pop_i   (q_pop)
  );

  tfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (head_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o      = res.kind;
  assign slot_o      = res.slot;
  assign value_o     = res.value;
  assign min_value_o = res.min_value;
  assign max_value_o = res.max_value;
  assign above_o     = res.above;
  assign urgency_o   = res.urgency;
  assign last_o      = res.last;

endmodule

// ===== tb/sv/tb_telemetry_frame_deframer_core.sv =====
module tb_telemetry_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       err;
  } link_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       line_error_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [1:0] slot_o;
  logic [7:0] value_o;
  logic [7:0] min_value_o;
  logic [7:0] max_value_o;
  logic       above_o;
  logic [1:0] urgency_o;
  logic       last_o;

  link_byte_t tx_bytes[$];
  result_t    pending_results[$];

  phase_e     parse_ph = PH_IDLE;
  int         fill_cnt = 0;
  logic [7:0] frame_buf[FRAME_BYTES];
  logic [7:0] ch_min[4];
  logic [7:0] ch_max[4];

  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   rx_taken = 0;
  int   errors = 0;
  int   frame_items = 0;
  bit   noisy = 1'b0;

  telemetry_frame_deframer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .line_error_i (line_error_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .value_o      (value_o),
    .min_value_o  (min_value_o),
    .max_value_o  (max_value_o),
    .above_o      (above_o),
    .urgency_o    (urgency_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    foreach (ch_min[i]) begin
      ch_min[i] = 8'h00;
      ch_max[i] = 8'h00;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 19)) : 0;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = FLAG_BYTE;
      1: b = ESC_BYTE;
      2: b = 8'h00;
      3: b = 8'hff;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic void put_byte(logic [7:0] b, logic err);
    link_byte_t it;
    it.b = b;
    it.err = err;
    tx_bytes.push_back(it);
  endfunction

  function automatic void put_data(logic [7:0] b);
    if (noisy && $urandom_range(0, 19) == 0) put_byte(8'($urandom), 1'b1);
    if (b == FLAG_BYTE || b == ESC_BYTE || (noisy && $urandom_range(0, 19) == 0)) begin
      put_byte(ESC_BYTE, 1'b0);
      put_byte(b ^ ESC_MASK, 1'b0);
    end else begin
      put_byte(b, 1'b0);
    end
  endfunction

  task automatic send_frame(input logic [7:0] body[$]);
    put_byte(FLAG_BYTE, 1'b0);
    foreach (body[i]) put_data(body[i]);
    put_byte(FLAG_BYTE, 1'b0);
    frame_items += body.size() + 2;
  endtask

  function automatic void store_data(logic [7:0] b);
    if (fill_cnt < FRAME_BYTES) begin
      frame_buf[fill_cnt] = b;
      fill_cnt++;
    end
  endfunction

  function automatic void close_frame();
    logic [7:0] ftype;
    logic [7:0] v;
    logic [2:0] cnt;
    result_t    r;
    ftype = frame_buf[0];
    if (ftype == TYPE_LINK) begin
      for (int i = 0; i < 4; i++) begin
        v = frame_buf[1 + i];
        if (i == 3) v = v >> 1;
        if (ch_max[i] == 8'h00 || ch_max[i] < v) ch_max[i] = v;
        if (ch_min[i] == 8'h00 || ch_min[i] > v) ch_min[i] = v;
        r = '0;
        r.kind = KIND_LINK;
        r.slot = 2'(i);
        r.value = v;
        r.min_value = ch_min[i];
        r.max_value = ch_max[i];
        r.last = (i == 3);
        pending_results.push_back(r);
      end
    end else if (ftype >= TYPE_ALARM_LO && ftype <= TYPE_ALARM_HI) begin
      r = '0;
      r.kind = KIND_ALARM;
      r.slot = 2'(ftype - TYPE_ALARM_LO);
      r.value = frame_buf[1];
      r.above = frame_buf[2][0];
      r.urgency = frame_buf[3][1:0] & URG_MASK;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else if (ftype == TYPE_USER) begin
      cnt = frame_buf[1][2:0] & USER_CNT_MASK;
      for (int i = 0; i < int'(cnt); i++) begin
        r = '0;
        r.kind = KIND_USER;
        r.value = frame_buf[3 + i];
        r.last = (i + 1 == int'(cnt));
        pending_results.push_back(r);
      end
    end else begin
      r = '0;
      r.kind = KIND_OTHER;
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic err);
    if (!err) begin
      case (parse_ph)
        PH_IDLE: begin
          if (b == FLAG_BYTE) begin
            fill_cnt = 0;
            parse_ph = PH_START;
          end
        end
        PH_START: begin
          if (b == ESC_BYTE) begin
            parse_ph = PH_ESC;
          end else if (b != FLAG_BYTE) begin
            store_data(b);
            parse_ph = PH_FRAME;
          end
        end
        PH_ESC: begin
          store_data(b ^ ESC_MASK);
          parse_ph = PH_FRAME;
        end
        default: begin
          if (b == ESC_BYTE) begin
            parse_ph = PH_ESC;
          end else if (b == FLAG_BYTE) begin
            parse_ph = PH_IDLE;
            close_frame();
          end else begin
            store_data(b);
          end
        end
      endcase
    end
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    link_byte_t it;
    logic       nv;
    nv = in_valid_i;
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      if (in_valid_i) tx_gap = draw_gap();
      if (tx_gap > 0) begin
        tx_gap--;
        nv = 1'b0;
      end else if (tx_bytes.size() != 0) begin
        it = tx_bytes.pop_front();
        rx_byte_i <= it.b;
        line_error_i <= it.err;
        nv = 1'b1;
      end else begin
        nv = 1'b0;
      end
    end
    in_valid_i <= nv;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        rx_taken++;
        rx_wait = (rx_taken == 12) ? 300 : draw_gap();
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      in_acc <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      in_acc <= in_valid_i && !in_stall_o;
      out_acc <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i, line_error_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d slot %0d value %0d", kind_o, slot_o, value_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("slot", want.slot, slot_o);
          check_field("value", want.value, value_o);
          check_field("min_value", want.min_value, min_value_o);
          check_field("max_value", want.max_value, max_value_o);
          check_field("above", want.above, above_o);
          check_field("urgency", want.urgency, urgency_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  initial begin
    logic [7:0] body[$];
    int         cnt;
    int         len;
    int         sel;

    put_byte(8'h55, 1'b0);
    put_byte(FLAG_BYTE, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(FLAG_BYTE, 1'b0);
    put_byte(FLAG_BYTE, 1'b0);
    put_byte(ESC_BYTE, 1'b0);
    put_byte(TYPE_LINK ^ ESC_MASK, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(FLAG_BYTE, 1'b0);
    send_frame('{TYPE_ALARM_HI, FLAG_BYTE, 8'hff, 8'h03});
    send_frame('{TYPE_USER, 8'h00});
    send_frame('{8'h00});

    noisy = 1'b1;
    frame_items = 0;
    while (frame_items < 120) begin
      body.delete();
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        repeat ($urandom_range(1, 6)) put_byte(pick_byte(), 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            body.push_back(TYPE_LINK);
            repeat (4) body.push_back(pick_byte());
          end
          1: begin
            body.push_back(TYPE_ALARM_LO + 8'($urandom_range(0, 3)));
            repeat (3) body.push_back(pick_byte());
          end
          2: begin
            cnt = $urandom_range(0, 7);
            body.push_back(TYPE_USER);
            body.push_back({5'($urandom), 3'(cnt)});
            body.push_back(pick_byte());
            repeat (cnt) body.push_back(pick_byte());
          end
          default: begin
            body.push_back(pick_byte());
            repeat ($urandom_range(0, 3)) body.push_back(pick_byte());
          end
        endcase
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          len = $urandom_range(1, body.size());
          while (body.size() > len) void'(body.pop_back());
        end else if (sel == 1) begin
          len = $urandom_range(17, 22);
          while (body.size() < len) body.push_back(pick_byte());
        end
        send_frame(body);
      end
    end

    wait (rst_ni);
    while (tx_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_telemetry_frame_deframer_core: PASS");
    end else begin
      $display("tb_telemetry_frame_deframer_core: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_telemetry_frame_deframer_core: FAIL");
    $finish;
  end

endmodule
